@@ hw/rtl/i2cram_pkg.sv @@
package i2cram_pkg;

	// Configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = 2'd1;

	localparam logic [6:0]  DEV_ADDR_RESET   = 7'd81;
	localparam logic [15:0] SLOT_TICKS_RESET = 16'd128;

	// Bus sequencer steps, one delay slot each
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START_A,   // release SDA
		ST_START_B,   // raise SCL
		ST_START_C,   // pull SDA low: (repeated) START
		ST_START_D,   // drop SCL
		ST_TX_BIT_LO, // SCL low, drive data bit
		ST_TX_BIT_HI, // SCL high
		ST_TX_ACK_LO,
		ST_TX_ACK_REL,
		ST_TX_ACK_HI,
		ST_TX_ACK_END,
		ST_RX_REL,
		ST_RX_LO,
		ST_RX_HI,
		ST_RX_SAMPLE,
		ST_RX_END,
		ST_NACK_REL,
		ST_NACK_HI,
		ST_NACK_LO,
		ST_NACK_END,
		ST_STOP_A,    // SCL and SDA low
		ST_STOP_B,    // raise SCL
		ST_STOP_C     // release SDA: STOP
	} step_t;

	// Which byte the transmit segment is sending
	typedef enum logic [1:0] {
		SEG_DEV,
		SEG_REG,
		SEG_DAT,
		SEG_RD
	} seg_t;

	// Per-tick result word
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] read_byte;
	} res_t;

endpackage

@@ hw/rtl/i2cram_seq.sv @@
module i2cram_seq import i2cram_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick_en,
	input  logic        go,
	input  logic        func,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	input  logic [6:0]  dev_addr,
	input  logic [15:0] slot_ticks,
	output res_t        res
);

	step_t       step_q, step_e, step_n;
	seg_t        seg_q, seg_e, seg_n;
	logic [2:0]  bit_q, bit_e, bit_n;
	logic [15:0] slot_q, slot_e, slot_ld, slot_n;
	logic [7:0]  shift_q, shift_e, shift_n;
	logic        func_q, func_e;
	logic [7:0]  reg_q, reg_e;
	logic [7:0]  data_q, data_e;
	logic [7:0]  rcv_q, rcv_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        start, active, slot_fire, slot_end, done;
	logic [7:0]  tx_byte;

	// Request latch on a go tick while idle
	assign start   = (step_q == ST_IDLE) && go;
	assign step_e  = start ? ST_START_A : step_q;
	assign seg_e   = start ? SEG_DEV : seg_q;
	assign bit_e   = start ? 3'd0 : bit_q;
	assign slot_e  = start ? 16'd0 : slot_q;
	assign shift_e = start ? 8'd0 : shift_q;
	assign func_e  = start ? func : func_q;
	assign reg_e   = start ? reg_addr : reg_q;
	assign data_e  = start ? write_data : data_q;

	// Slot timer: pin action on the first tick, advance on the last
	assign active    = (step_e != ST_IDLE);
	assign slot_fire = active && (slot_e == 16'd0);
	assign slot_ld   = slot_fire ? ((slot_ticks == 16'd0) ? 16'd1 : slot_ticks) : slot_e;
	assign slot_n    = active ? (slot_ld - 16'd1) : slot_e;
	assign slot_end  = active && (slot_n == 16'd0);

	// Byte on the wire for the current transmit segment
	always_comb begin
		case (seg_e)
			SEG_DEV: tx_byte = {dev_addr, 1'b0};
			SEG_REG: tx_byte = reg_e;
			SEG_DAT: tx_byte = data_e;
			SEG_RD:  tx_byte = {dev_addr, 1'b1};
			default: tx_byte = {dev_addr, 1'b0};
		endcase
	end

	// Pin actions at the start of a slot
	always_comb begin
		scl_n   = scl_q;
		sda_n   = sda_q;
		shift_n = shift_e;
		rcv_n   = rcv_q;
		if (slot_fire) begin
			case (step_e)
				ST_START_A:    sda_n = 1'b1;
				ST_START_B:    scl_n = 1'b1;
				ST_START_C:    sda_n = 1'b0;
				ST_START_D:    scl_n = 1'b0;
				ST_TX_BIT_LO: begin
					scl_n = 1'b0;
					sda_n = tx_byte[~bit_e];
				end
				ST_TX_BIT_HI:  scl_n = 1'b1;
				ST_TX_ACK_LO:  scl_n = 1'b0;
				ST_TX_ACK_REL: sda_n = 1'b1;
				ST_TX_ACK_HI:  scl_n = 1'b1;
				ST_TX_ACK_END: scl_n = 1'b0;
				ST_RX_REL:     sda_n = 1'b1;
				ST_RX_LO:      scl_n = 1'b0;
				ST_RX_HI:      scl_n = 1'b1;
				ST_RX_SAMPLE:  shift_n = {shift_e[6:0], sda_in};
				ST_RX_END: begin
					scl_n = 1'b0;
					rcv_n = shift_e;
				end
				ST_NACK_REL:   sda_n = 1'b1;
				ST_NACK_HI:    scl_n = 1'b1;
				ST_NACK_LO:    scl_n = 1'b0;
				ST_STOP_A: begin
					scl_n = 1'b0;
					sda_n = 1'b0;
				end
				ST_STOP_B:     scl_n = 1'b1;
				ST_STOP_C:     sda_n = 1'b1;
				default: ;
			endcase
		end
	end

	// Step sequencing at the end of a slot
	always_comb begin
		step_n = step_e;
		seg_n  = seg_e;
		bit_n  = bit_e;
		done   = 1'b0;
		if (slot_end) begin
			case (step_e)
				ST_START_A:    step_n = ST_START_B;
				ST_START_B:    step_n = ST_START_C;
				ST_START_C:    step_n = ST_START_D;
				ST_START_D:    step_n = ST_TX_BIT_LO;
				ST_TX_BIT_LO:  step_n = ST_TX_BIT_HI;
				ST_TX_BIT_HI: begin
					if (bit_e == 3'd7) begin
						bit_n  = 3'd0;
						step_n = ST_TX_ACK_LO;
					end else begin
						bit_n  = bit_e + 3'd1;
						step_n = ST_TX_BIT_LO;
					end
				end
				ST_TX_ACK_LO:  step_n = ST_TX_ACK_REL;
				ST_TX_ACK_REL: step_n = ST_TX_ACK_HI;
				ST_TX_ACK_HI:  step_n = ST_TX_ACK_END;
				ST_TX_ACK_END: begin
					case (seg_e)
						SEG_DEV: begin
							seg_n  = SEG_REG;
							step_n = ST_TX_BIT_LO;
						end
						SEG_REG: begin
							// read turns around with a repeated START
							if (func_e) begin
								seg_n  = SEG_RD;
								step_n = ST_START_A;
							end else begin
								seg_n  = SEG_DAT;
								step_n = ST_TX_BIT_LO;
							end
						end
						SEG_DAT: step_n = ST_STOP_A;
						SEG_RD:  step_n = ST_RX_REL;
						default: step_n = ST_IDLE;
					endcase
				end
				ST_RX_REL:     step_n = ST_RX_LO;
				ST_RX_LO:      step_n = ST_RX_HI;
				ST_RX_HI:      step_n = ST_RX_SAMPLE;
				ST_RX_SAMPLE: begin
					if (bit_e == 3'd7) begin
						bit_n  = 3'd0;
						step_n = ST_RX_END;
					end else begin
						bit_n  = bit_e + 3'd1;
						step_n = ST_RX_REL;
					end
				end
				ST_RX_END:     step_n = ST_NACK_REL;
				ST_NACK_REL:   step_n = ST_NACK_HI;
				ST_NACK_HI:    step_n = ST_NACK_LO;
				ST_NACK_LO:    step_n = ST_NACK_END;
				ST_NACK_END:   step_n = ST_STOP_A;
				ST_STOP_A:     step_n = ST_STOP_B;
				ST_STOP_B:     step_n = ST_STOP_C;
				ST_STOP_C: begin
					step_n = ST_IDLE;
					done   = 1'b1;
				end
				default:       step_n = ST_IDLE;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			seg_q  <= SEG_DEV;
			bit_q  <= 3'd0;
			slot_q <= 16'd0;
			rcv_q  <= 8'd0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else if (tick_en) begin
			step_q <= step_n;
			seg_q  <= seg_n;
			bit_q  <= bit_n;
			slot_q <= slot_n;
			rcv_q  <= rcv_n;
			scl_q  <= scl_n;
			sda_q  <= sda_n;
		end
	end

	// Request and shift data
	always_ff @(posedge clk) begin
		if (tick_en) begin
			shift_q <= shift_n;
			func_q  <= func_e;
			reg_q   <= reg_e;
			data_q  <= data_e;
		end
	end

	assign res.scl       = scl_n;
	assign res.sda       = sda_n;
	assign res.busy      = (step_n != ST_IDLE);
	assign res.done      = done;
	assign res.read_byte = rcv_n;

endmodule

@@ hw/rtl/i2c_register_access_master_top.sv @@
// The result word for a tick is registered and appears in the cycle after the tick word is taken.
// Throughput: one tick word per cycle; the input side keeps taking words while the
// output register drains, and stalls only when a result waits with out_ready low.
// Bus timing is set by slot_ticks ticks per sequencer step (zero acts as one), counted by the slot timer.
// Reset (arst_n low, asynchronous): sequencer idle, its SCL and SDA state released high,
// its received byte zero, device_address 81, slot_ticks 128, output register empty.
module i2c_register_access_master_top import i2cram_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	// tick words in
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 go,
	input  logic                 func,
	input  logic [7:0]           reg_addr,
	input  logic [7:0]           write_data,
	input  logic                 sda_in,
	// result words out
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl,
	output logic                 sda_out,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [7:0]           read_byte
);

	logic [6:0]  dev_addr_q;
	logic [15:0] slot_ticks_q;
	logic        out_valid_q;
	res_t        res, res_q;
	logic        tick_en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= DEV_ADDR_RESET;
			slot_ticks_q <= SLOT_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEV_ADDR:   dev_addr_q   <= cfg_data[6:0];
				CFG_SLOT_TICKS: slot_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a word whenever the output register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign tick_en  = in_valid && in_ready;

	i2cram_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_en    (tick_en),
		.go         (go),
		.func       (func),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.sda_in     (sda_in),
		.dev_addr   (dev_addr_q),
		.slot_ticks (slot_ticks_q),
		.res        (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl       = res_q.scl;
	assign sda_out   = res_q.sda;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign read_byte = res_q.read_byte;

`ifndef SYNTHESIS
	// every accepted tick yields a result word on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en |=> out_valid)
		else $error("accepted tick produced no result word");

	// a finished transaction leaves the bus released and the block idle
	a_done_bus_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && scl && sda_out)
		else $error("done without a released bus");

	// a waiting result word holds until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({scl, sda_out, busy_res, done_res, read_byte}))
		else $error("result word changed while waiting");
`endif

endmodule

@@ dv/tb_i2c_register_access_master_top.sv @@
`timescale 1ns / 100ps

module tb_i2c_register_access_master_top;
	import i2cram_pkg::*;

	// Transaction kinds on the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Register index that maps to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	// Sequencer steps of the predictor, one delay slot each
	localparam int STEP_IDLE     = 0;
	localparam int STEP_START    = 1;
	localparam int STEP_DEV      = 5;
	localparam int STEP_REG      = 11;
	localparam int STEP_DAT      = 17;
	localparam int STEP_STOP     = 23;
	localparam int STEP_RSTART   = 26;
	localparam int STEP_RDADDR   = 30;
	localparam int STEP_RCV      = 36;
	localparam int STEP_SAMPLE   = 39;
	localparam int STEP_RCV_END  = 40;
	localparam int STEP_NACK     = 41;
	localparam int STEP_NACK_END = 44;

	// Delay slots in a whole write and a whole read
	localparam int WR_SLOTS = 67;
	localparam int RD_SLOTS = 108;

	// SDA levels fed during a transaction
	localparam int SDA_LOW    = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_RANDOM = 2;

	localparam int MAX_GAP      = 12;
	localparam int LONG_HOLD    = 80;
	localparam int LONG_HOLD_AT = 650;
	localparam int WATCHDOG_MAX = 3000;

	typedef struct packed {
		logic       go;
		logic       func;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 go = 1'b0;
	logic                 func = 1'b0;
	logic [7:0]           reg_addr = '0;
	logic [7:0]           write_data = '0;
	logic                 sda_in = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 scl;
	logic                 sda_out;
	logic                 busy_res;
	logic                 done_res;
	logic [7:0]           read_byte;

	i2c_register_access_master_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.go        (go),
		.func      (func),
		.reg_addr  (reg_addr),
		.write_data(write_data),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl       (scl),
		.sda_out   (sda_out),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_byte (read_byte)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bus master state as predicted
	logic [6:0]  p_dev_addr = DEV_ADDR_RESET;
	logic [15:0] p_slot = SLOT_TICKS_RESET;
	int          seq_step = STEP_IDLE;
	logic [2:0]  bit_cnt = '0;
	logic [15:0] slot_cnt = '0;
	logic [7:0]  shift_reg = '0;
	logic        lat_func = 1'b0;
	logic [7:0]  lat_reg = '0;
	logic [7:0]  lat_data = '0;
	logic [7:0]  rx_byte = '0;
	logic        pin_scl = 1'b1;
	logic        pin_sda = 1'b1;

	tick_t tick_q[$];
	res_t  bus_expect_q[$];

	int items_queued = 0;
	int words_checked = 0;
	int mismatches = 0;
	int txn_done = 0;
	int reads_done = 0;

	function automatic logic starts_byte(input int s);
		return s == STEP_DEV || s == STEP_REG || s == STEP_DAT || s == STEP_RDADDR;
	endfunction

	// Byte shifted out by the segment starting at step s
	function automatic logic [7:0] byte_for(input int s);
		logic [7:0] wr;
		wr = {p_dev_addr, 1'b0};
		if (s == STEP_DEV)
			return wr;
		if (s == STEP_REG)
			return lat_reg;
		if (s == STEP_DAT)
			return lat_data;
		return wr | 8'h01;
	endfunction

	// Pin change made on the first tick of a slot
	function automatic void pin_action(input int s);
		logic [7:0] tx;
		if (starts_byte(s)) begin
			tx = byte_for(s);
			pin_scl = 1'b0;
			pin_sda = tx[3'd7 - bit_cnt];
		end else if (starts_byte(s - 1)) begin
			pin_scl = 1'b1;
		end else if (starts_byte(s - 2)) begin
			pin_scl = 1'b0;
		end else if (starts_byte(s - 3)) begin
			pin_sda = 1'b1;
		end else if (starts_byte(s - 4)) begin
			pin_scl = 1'b1;
		end else if (starts_byte(s - 5)) begin
			pin_scl = 1'b0;
		end else begin
			case (s)
				STEP_START, STEP_RSTART: pin_sda = 1'b1;
				STEP_START + 1, STEP_RSTART + 1: pin_scl = 1'b1;
				STEP_START + 2, STEP_RSTART + 2: pin_sda = 1'b0;
				STEP_START + 3, STEP_RSTART + 3: pin_scl = 1'b0;
				STEP_STOP: begin
					pin_scl = 1'b0;
					pin_sda = 1'b0;
				end
				STEP_STOP + 1: pin_scl = 1'b1;
				STEP_STOP + 2: pin_sda = 1'b1;
				STEP_RCV: pin_sda = 1'b1;
				STEP_RCV + 1: pin_scl = 1'b0;
				STEP_RCV + 2: pin_scl = 1'b1;
				STEP_SAMPLE: shift_reg = {shift_reg[6:0], 1'b0};
				STEP_RCV_END: begin
					pin_scl = 1'b0;
					rx_byte = shift_reg;
				end
				STEP_NACK: pin_sda = 1'b1;
				STEP_NACK + 1: pin_scl = 1'b1;
				STEP_NACK + 2: pin_scl = 1'b0;
				default: ;
			endcase
		end
	endfunction

	// Step to follow when a slot runs out; 1 when STOP has just finished
	function automatic logic next_slot();
		int s;
		s = seq_step;
		if (starts_byte(s - 1) || s == STEP_SAMPLE) begin
			if (bit_cnt == 3'd7) begin
				bit_cnt = 3'd0;
				seq_step = s + 1;
			end else begin
				bit_cnt = bit_cnt + 3'd1;
				seq_step = (s == STEP_SAMPLE) ? STEP_RCV : s - 1;
			end
			return 1'b0;
		end
		if (s == STEP_REG + 5) begin
			seq_step = (lat_func == FUNC_READ) ? STEP_RSTART : STEP_DAT;
			return 1'b0;
		end
		if (s == STEP_DAT + 5 || s == STEP_NACK_END) begin
			seq_step = STEP_STOP;
			return 1'b0;
		end
		if (s == STEP_STOP + 2) begin
			seq_step = STEP_IDLE;
			return 1'b1;
		end
		if (s >= STEP_START && s < STEP_NACK_END) begin
			seq_step = s + 1;
			return 1'b0;
		end
		seq_step = STEP_IDLE;
		return 1'b0;
	endfunction

	// One tick of the bus master: expected result word
	function automatic res_t bus_tick(input tick_t t);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (seq_step == STEP_IDLE && t.go) begin
			lat_func = t.func;
			lat_reg = t.reg_addr;
			lat_data = t.write_data;
			seq_step = STEP_START;
			bit_cnt = 3'd0;
			slot_cnt = 16'd0;
			shift_reg = 8'd0;
		end
		if (seq_step != STEP_IDLE) begin
			if (slot_cnt == 16'd0) begin
				pin_action(seq_step);
				if (seq_step == STEP_SAMPLE)
					shift_reg[0] = t.sda_in;
				slot_cnt = (p_slot == 16'd0) ? 16'd1 : p_slot;
			end
			slot_cnt = slot_cnt - 16'd1;
			if (slot_cnt == 16'd0)
				fin = next_slot();
		end
		if (fin) begin
			txn_done++;
			if (lat_func == FUNC_READ)
				reads_done++;
		end
		r.scl = pin_scl;
		r.sda = pin_sda;
		r.busy = (seq_step != STEP_IDLE);
		r.done = fin;
		r.read_byte = rx_byte;
		return r;
	endfunction

	// Word driver: launches queued ticks at the falling edge
	logic  in_fire = 1'b0;
	logic  out_fire = 1'b0;
	logic  no_gaps = 1'b0;
	int    gap_left = 0;
	tick_t drv_word;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || in_fire) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				drv_word = tick_q.pop_front();
				go <= drv_word.go;
				func <= drv_word.func;
				reg_addr <= drv_word.reg_addr;
				write_data <= drv_word.write_data;
				sda_in <= drv_word.sda_in;
				in_valid <= 1'b1;
				gap_left <= no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
				if ($urandom_range(0, 99) == 0)
					no_gaps <= !no_gaps;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls plus one long hold-off
	int stall_left = 0;
	int stall_draw;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (out_fire) begin
			if (words_checked == LONG_HOLD_AT)
				stall_draw = LONG_HOLD;
			else
				stall_draw = no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
			stall_left <= stall_draw;
			out_ready <= (stall_draw == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predicts on accepted ticks, checks accepted results
	tick_t acc_word;
	res_t  got_word;
	res_t  want_word;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			out_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			out_fire <= out_valid && out_ready;
			if (in_valid && in_ready) begin
				acc_word = {go, func, reg_addr, write_data, sda_in};
				bus_expect_q.push_back(bus_tick(acc_word));
			end
			if (out_valid && out_ready) begin
				got_word = {scl, sda_out, busy_res, done_res, read_byte};
				if (bus_expect_q.size() == 0) begin
					if (mismatches < 10)
						$display("ERROR: result word %0d with nothing expected: scl=%b sda=%b busy=%b done=%b rd=%02h",
							words_checked, got_word.scl, got_word.sda, got_word.busy,
							got_word.done, got_word.read_byte);
					mismatches++;
				end else begin
					want_word = bus_expect_q.pop_front();
					if (got_word !== want_word) begin
						if (mismatches < 10)
							$display("ERROR: word %0d exp scl=%b sda=%b busy=%b done=%b rd=%02h, got scl=%b sda=%b busy=%b done=%b rd=%02h",
								words_checked, want_word.scl, want_word.sda, want_word.busy,
								want_word.done, want_word.read_byte, got_word.scl, got_word.sda,
								got_word.busy, got_word.done, got_word.read_byte);
						mismatches++;
					end
				end
				words_checked++;
			end
		end
	end

	// Watchdog on cycles without any handshake
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("ERROR: no handshake for %0d cycles", idle_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Stimulus helpers
	task automatic push_tick(input logic g, input logic f, input logic [7:0] ra,
		input logic [7:0] wd, input logic sd);
		tick_t t;
		t.go = g;
		t.func = f;
		t.reg_addr = ra;
		t.write_data = wd;
		t.sda_in = sd;
		tick_q.push_back(t);
		items_queued++;
	endtask

	function automatic logic pick_sda(input int mode);
		if (mode == SDA_RANDOM)
			return 1'($urandom_range(0, 1));
		return (mode == SDA_HIGH);
	endfunction

	task automatic push_idle(input int n);
		repeat (n)
			push_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
				1'($urandom_range(0, 1)));
	endtask

	// One whole transaction; go during the body lands while busy and is dropped
	task automatic push_txn(input logic f, input logic [7:0] ra, input logic [7:0] wd,
		input int sda_mode);
		int len;
		len = ((f == FUNC_READ) ? RD_SLOTS : WR_SLOTS) * ((p_slot == 16'd0) ? 1 : int'(p_slot));
		push_tick(1'b1, f, ra, wd, pick_sda(sda_mode));
		repeat (len - 1)
			push_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 8'($urandom),
				8'($urandom), pick_sda(sda_mode));
	endtask

	task automatic random_txns(input int budget);
		int first;
		first = items_queued;
		while (items_queued - first < budget) begin
			if ($urandom_range(0, 7) == 0)
				push_idle($urandom_range(1, 20));
			push_txn(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), SDA_RANDOM);
			push_idle($urandom_range(0, 3));
		end
	endtask

	// Wait until no word is queued, in flight or expected
	task automatic drain();
		while (tick_q.size() != 0 || in_valid || bus_expect_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_DEV_ADDR)
			p_dev_addr = val[6:0];
		else if (idx == CFG_SLOT_TICKS)
			p_slot = val;
	endtask

	task automatic configure(input logic [6:0] dev, input logic [15:0] slot);
		drain();
		set_reg(CFG_DEV_ADDR, {9'd0, dev});
		set_reg(CFG_SLOT_TICKS, slot);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a write that is still running when the settings change
		push_tick(1'b1, FUNC_WRITE, 8'($urandom), 8'($urandom), 1'b1);
		push_idle(99);

		// Fastest bus, address zero, plus a write to an unmapped index
		configure(7'd0, 16'd1);
		set_reg(CFG_IDX_UNUSED, 16'hFFFF);
		@(negedge clk);
		cfg_we <= 1'b0;
		push_idle(120);
		push_txn(FUNC_WRITE, 8'h00, 8'hFF, SDA_RANDOM);
		push_txn(FUNC_READ, 8'hFF, 8'h00, SDA_HIGH);
		push_txn(FUNC_WRITE, 8'hFF, 8'h00, SDA_RANDOM);
		push_txn(FUNC_READ, 8'h00, 8'hFF, SDA_LOW);

		// Zero slot length behaves as one tick; top address
		configure(7'd127, 16'd0);
		random_txns(150);

		configure(7'($urandom_range(0, 127)), 16'd2);
		random_txns(240);

		configure(7'($urandom_range(0, 127)), 16'd3);
		random_txns(100);

		// Longest slot: a read that only gets started
		configure(DEV_ADDR_RESET, 16'hFFFF);
		push_tick(1'b1, FUNC_READ, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		push_idle(60);

		drain();
		repeat (20) @(posedge clk);
		if (bus_expect_q.size() != 0) begin
			$display("ERROR: %0d result words never arrived", bus_expect_q.size());
			mismatches += bus_expect_q.size();
		end
		$display("Drove %0d bus ticks over six timing/address settings, checked %0d result words",
			items_queued, words_checked);
		$display("Bus transactions completed: %0d (%0d reads), mismatches: %0d",
			txn_done, reads_done, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
